// File: sv/tssl_pkg.sv
// Package for the thread state and sleep ticker: sizes, event codes,
// the command word passed from front to back and the port word types.
// No dependencies.
package tssl_pkg;

   localparam int THREADS     = 8;
   localparam int COUNT_WIDTH = 16;
   localparam int IDX_W       = (THREADS > 1) ? $clog2(THREADS) : 1;
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   // largest countdown value, kept as 32 bits for comparison with sleep_ticks
   localparam logic [31:0] COUNT_MAX = 32'((33'd1 << COUNT_WIDTH) - 33'd1);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(THREADS - 1);

   typedef enum logic [2:0] {
      MODE_TICK    = 3'd0,
      MODE_CREATE  = 3'd1,
      MODE_SLEEP   = 3'd2,
      MODE_DISABLE = 3'd3,
      MODE_SUSPEND = 3'd4,
      MODE_RESUME  = 3'd5,
      MODE_QUERY   = 3'd6
   } tssl_mode_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_TICK,
      ST_REPORT
   } tssl_state_type;

   typedef struct packed {
      logic [2:0]  mode;
      logic [2:0]  thread;
      logic [15:0] sleep_ticks;
      logic        start_suspended;
   } tssl_req_type;

   typedef struct packed {
      logic        thread_enabled;
      logic        thread_suspended;
      logic        thread_sleeping;
      logic [7:0]  enabled_mask;
      logic [7:0]  sleeping_mask;
      logic [31:0] uptime_ticks;
   } tssl_rsp_type;

   // classified event as the back end sees it
   typedef struct packed {
      tssl_mode_type          op;
      logic [THREADS-1:0]     sel;
      logic [IDX_W-1:0]       idx;
      logic [COUNT_WIDTH-1:0] count;
      logic                   start_suspended;
   } tssl_cmd_type;

endpackage

// File: sv/tssl_front.sv
// Front end: takes request words, decodes the mode, range-checks the thread
// and fixes up the sleep count, then hands the command to the queue.
// Depends on tssl_pkg.
module tssl_front import tssl_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   output logic         full,
   input  tssl_req_type req_data,
   output logic         cmd_push,
   input  logic         cmd_full,
   output tssl_cmd_type cmd_data
);

   logic         valid_ff, valid_in;
   tssl_cmd_type cmd_ff, cmd_in;
   tssl_cmd_type decoded;
   logic         accept;
   logic [31:0]  ticks32;

   assign full   = valid_ff && cmd_full;
   assign accept = push && !full;

   always_comb begin
      ticks32 = 32'(req_data.sleep_ticks);
      if (ticks32 == 32'd0) begin
         ticks32 = 32'd1;
      end
      if (ticks32 > COUNT_MAX) begin
         ticks32 = COUNT_MAX;
      end
      decoded.sel             = THREADS'(8'd1 << req_data.thread);
      decoded.idx             = req_data.thread[IDX_W-1:0];
      decoded.count           = ticks32[COUNT_WIDTH-1:0];
      decoded.start_suspended = req_data.start_suspended;
      case (req_data.mode)
         MODE_TICK:    decoded.op = MODE_TICK;
         MODE_CREATE:  decoded.op = MODE_CREATE;
         MODE_SLEEP:   decoded.op = MODE_SLEEP;
         MODE_DISABLE: decoded.op = MODE_DISABLE;
         MODE_SUSPEND: decoded.op = MODE_SUSPEND;
         MODE_RESUME:  decoded.op = MODE_RESUME;
         default:      decoded.op = MODE_QUERY;
      endcase
      // out-of-range thread: nothing changes but a tick still counts
      if (decoded.sel == '0 && decoded.op != MODE_TICK) begin
         decoded.op = MODE_QUERY;
      end
   end

   assign valid_in = accept || (valid_ff && cmd_full);
   assign cmd_in   = accept ? decoded : cmd_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      cmd_ff <= cmd_in;
   end

   assign cmd_push = valid_ff;
   assign cmd_data = cmd_ff;

endmodule

// File: sv/tssl_queue.sv
// Short command queue between front and back ends.
// Depends on tssl_pkg.
module tssl_queue import tssl_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  tssl_cmd_type push_data,
   output logic         full,
   input  logic         pop,
   output tssl_cmd_type pop_data,
   output logic         empty
);

   tssl_cmd_type      mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]   count_ff, count_in;
   logic              do_push, do_pop;

   assign full    = count_ff == (QPTR_W + 1)'(QUEUE_DEPTH);
   assign empty   = count_ff == '0;
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign pop_data = mem_ff[rd_ptr_ff];

endmodule

// File: sv/tssl_back.sv
// Back end: holds the thread flags, countdowns and uptime, carries out one
// command at a time (a tick walks the countdowns one per cycle) and keeps
// the result word register. Depends on tssl_pkg.
module tssl_back import tssl_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         cmd_empty,
   input  tssl_cmd_type cmd_data,
   output logic         cmd_pop,
   output logic         empty,
   input  logic         pop,
   output tssl_rsp_type rsp_data
);

   tssl_state_type         state_ff, state_in;
   logic [THREADS-1:0]     enabled_ff, enabled_in;
   logic [THREADS-1:0]     suspended_ff, suspended_in;
   logic [THREADS-1:0]     sleeping_ff, sleeping_in;
   logic [31:0]            uptime_ff, uptime_in;
   logic [IDX_W-1:0]       idx_ff, idx_in;
   logic [THREADS-1:0]     sel_ff, sel_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   tssl_rsp_type           rsp_ff, rsp_in;
   logic [COUNT_WIDTH-1:0] countdown_ff [THREADS];
   logic [COUNT_WIDTH-1:0] cd_rdata;
   logic                   cd_we;
   logic [IDX_W-1:0]       cd_waddr;
   logic [COUNT_WIDTH-1:0] cd_wdata;
   logic                   slot_free;

   assign cd_rdata  = countdown_ff[idx_ff];
   assign slot_free = !rsp_valid_ff || pop;

   always_comb begin
      state_in     = state_ff;
      enabled_in   = enabled_ff;
      suspended_in = suspended_ff;
      sleeping_in  = sleeping_ff;
      uptime_in    = uptime_ff;
      idx_in       = idx_ff;
      sel_in       = sel_ff;
      rsp_valid_in = rsp_valid_ff && !pop;
      rsp_in       = rsp_ff;
      cmd_pop      = 1'b0;
      cd_we        = 1'b0;
      cd_waddr     = cmd_data.idx;
      cd_wdata     = cmd_data.count;
      case (state_ff)
         ST_IDLE: begin
            if (!cmd_empty) begin
               cmd_pop  = 1'b1;
               sel_in   = cmd_data.sel;
               state_in = ST_REPORT;
               case (cmd_data.op)
                  MODE_TICK: begin
                     uptime_in = uptime_ff + 32'd1;
                     idx_in    = '0;
                     state_in  = ST_TICK;
                  end
                  MODE_CREATE: begin
                     enabled_in  = enabled_ff | cmd_data.sel;
                     sleeping_in = sleeping_ff & ~cmd_data.sel;
                     if (cmd_data.start_suspended) begin
                        suspended_in = suspended_ff | cmd_data.sel;
                     end else begin
                        suspended_in = suspended_ff & ~cmd_data.sel;
                     end
                  end
                  MODE_SLEEP: begin
                     cd_we       = 1'b1;
                     sleeping_in = sleeping_ff | cmd_data.sel;
                  end
                  MODE_DISABLE: enabled_in   = enabled_ff & ~cmd_data.sel;
                  MODE_SUSPEND: suspended_in = suspended_ff | cmd_data.sel;
                  MODE_RESUME:  suspended_in = suspended_ff & ~cmd_data.sel;
                  default: ;
               endcase
            end
         end
         ST_TICK: begin
            cd_waddr = idx_ff;
            if (sleeping_ff[idx_ff]) begin
               cd_we = 1'b1;
               if (cd_rdata <= COUNT_WIDTH'(1)) begin
                  cd_wdata             = '0;
                  sleeping_in[idx_ff] = 1'b0;
               end else begin
                  cd_wdata = cd_rdata - COUNT_WIDTH'(1);
               end
            end
            if (idx_ff == LAST_IDX) begin
               state_in = ST_REPORT;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         ST_REPORT: begin
            if (slot_free) begin
               rsp_valid_in            = 1'b1;
               rsp_in.thread_enabled   = |(enabled_ff & sel_ff);
               rsp_in.thread_suspended = |(enabled_ff & suspended_ff & sel_ff);
               rsp_in.thread_sleeping  = |(enabled_ff & sleeping_ff & sel_ff);
               rsp_in.enabled_mask     = 8'(enabled_ff);
               rsp_in.sleeping_mask    = 8'(sleeping_ff);
               rsp_in.uptime_ticks     = uptime_ff;
               state_in                = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         enabled_ff   <= THREADS'(1);
         suspended_ff <= '0;
         sleeping_ff  <= '0;
         uptime_ff    <= '0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         enabled_ff   <= enabled_in;
         suspended_ff <= suspended_in;
         sleeping_ff  <= sleeping_in;
         uptime_ff    <= uptime_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      sel_ff <= sel_in;
      rsp_ff <= rsp_in;
   end

   // countdowns only matter while the sleeping flag is set, so no reset
   always_ff @(posedge clock) begin
      if (cd_we) begin
         countdown_ff[cd_waddr] <= cd_wdata;
      end
   end

   assign empty    = !rsp_valid_ff;
   assign rsp_data = rsp_ff;

endmodule

// File: sv/thread_state_sleep_ticker.sv
// Thread state and sleep ticker. Each request word is one event (tick, create,
// sleep, disable, suspend, resume, query) and gives exactly one response word
// with the named thread's status, the enabled and sleeping masks and uptime,
// all as they stand after the event. Requests are decoded into a register
// stage and a two-entry command queue, so push is taken while the back end is
// busy. The back end goes from idle to a report state for a thread operation;
// for a tick it first visits the sleep countdowns one per cycle in a tick state,
// which sets the sustained rate. A response waits in an output register until
// popped; the back end moves to the next event once that register is free.
module thread_state_sleep_ticker import tssl_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   output logic         full,
   input  tssl_req_type req_data,
   output logic         empty,
   input  logic         pop,
   output tssl_rsp_type rsp_data
);

   logic         q_push, q_full, q_pop, q_empty;
   tssl_cmd_type q_wdata, q_rdata;

   tssl_front u_front (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .full     (full),
      .req_data (req_data),
      .cmd_push (q_push),
      .cmd_full (q_full),
      .cmd_data (q_wdata)
   );

   tssl_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_wdata),
      .full      (q_full),
      .pop       (q_pop),
      .pop_data  (q_rdata),
      .empty     (q_empty)
   );

   tssl_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_empty (q_empty),
      .cmd_data  (q_rdata),
      .cmd_pop   (q_pop),
      .empty     (empty),
      .pop       (pop),
      .rsp_data  (rsp_data)
   );

`ifndef ASSERT_OFF
   a_no_pop_when_empty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_empty)
      else $error("command popped from empty queue");

   a_front_holds_when_full: assert property (@(posedge clock) disable iff (reset)
      (q_push && q_full) |=> q_push)
      else $error("front dropped a word while the queue was full");

   // checked on the first edge out of reset
   a_ready_after_reset: assert property (@(posedge clock)
      (!reset && $past(reset)) |-> (!full && empty))
      else $error("queue not clear after reset");
`endif

endmodule
